### rtl/rdc_pkg.sv
// Shared types and constants for the range distinct count core.
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

	// Fixed field widths of the item and result words
	localparam int KIND_W  = 1;
	localparam int INDEX_W = 10;
	localparam int VALUE_W = 16;
	localparam int COUNT_W = 11;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
	localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

	localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 11'd1024;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SCAN,
		ST_FLUSH,
		ST_DONE
	} rdc_state_t;

	// Sequencer to compare unit control
	typedef struct packed {
		logic clear;
		logic vld;
		logic fetch;
		logic query;
	} rdc_ctl_t;

endpackage

`default_nettype wire

### rtl/range_distinct_count_core.sv
// Top level of the range distinct count core: sequencer, store and handshakes.
//
//  channel  | signals                                           | dir
//  ---------+---------------------------------------------------+-----
//  in       | in_valid, in_ready, kind, entry_index, entry_value,| in
//           | range_low, range_high                             |
//  out      | out_valid, out_ready, distinct_count              | out
//  cfg      | cfg_valid, cfg_ready, entry_count                 | in
//
// Each store word holds a value and the index of the nearest earlier entry
// with the same value. A query counts entries that have no earlier match or
// whose earlier match lies below range_low: one store read per cycle. An empty
// range skips the scan. A load reads its target, then sweeps all DEPTH
// entries through the one compare unit, fixing the back links.
// in_ready is high only in idle. A finished result waits in the output
// register; a following load proceeds, a following query holds at its end
// until the output word is taken. cfg_ready is always high.
// No clearing pass after reset; arst_n clears control state only.
`timescale 1ns / 1ps
`default_nettype none

module range_distinct_count_core #(
	parameter int DEPTH      = 1024,
	parameter int VALUE_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic        [rdc_pkg::KIND_W-1:0]   kind,
	input  wire logic        [rdc_pkg::INDEX_W-1:0]  entry_index,
	input  wire logic signed [rdc_pkg::VALUE_W-1:0]  entry_value,
	input  wire logic        [rdc_pkg::INDEX_W-1:0]  range_low,
	input  wire logic        [rdc_pkg::INDEX_W-1:0]  range_high,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic             [rdc_pkg::COUNT_W-1:0]  distinct_count,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic        [rdc_pkg::COUNT_W-1:0]  entry_count
);
	import rdc_pkg::*;

	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int WORD_W  = VALUE_BITS + 1 + ADDR_W;
	localparam int WIDE_W  = (ADDR_W + 1 > COUNT_W) ? ADDR_W + 1 : COUNT_W;
	localparam int VEXT_W  = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam logic [WIDE_W-1:0] DEPTH_W = WIDE_W'(DEPTH);

	rdc_state_t state_q, state_d;

	logic [COUNT_W-1:0]    entry_count_q;
	logic                  op_query_q;
	logic [ADDR_W-1:0]     k_q, lo_q, end_q, rd_addr_q;
	logic [VALUE_BITS-1:0] newv_q;
	logic                  vld_s1, fetch_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic                  out_valid_q;
	logic [COUNT_W-1:0]    distinct_count_q;

	logic                  accept, rd_issue, done_fire;
	logic [ADDR_W-1:0]     rd_addr;
	logic [WIDE_W-1:0]     cnt_w, used_w, last_w, lo_w, hi_w, hic_w, idx_w;
	logic [VEXT_W-1:0]     vext;
	logic                  is_query, q_empty, ld_in_range;

	rdc_ctl_t              ctl;
	logic [WORD_W-1:0]     rd_word, wdata;
	logic                  we;
	logic [COUNT_W-1:0]    count;

	// Decode the item word at accept
	assign cnt_w       = WIDE_W'(entry_count_q);
	assign used_w      = (cnt_w > DEPTH_W) ? DEPTH_W : cnt_w;
	assign last_w      = used_w - 1'b1;
	assign lo_w        = WIDE_W'(range_low);
	assign hi_w        = WIDE_W'(range_high);
	assign hic_w       = (hi_w > last_w) ? last_w : hi_w;
	assign idx_w       = WIDE_W'(entry_index);
	assign vext        = VEXT_W'($unsigned(entry_value));
	assign is_query    = (kind == KIND_QUERY);
	assign q_empty     = (used_w == '0) || (lo_w >= used_w) || (lo_w > hic_w);
	assign ld_in_range = (idx_w < DEPTH_W);
	assign accept      = in_valid && in_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_query) begin
						state_d = q_empty ? ST_DONE : ST_SCAN;
					end else if (ld_in_range) begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: state_d = ST_SCAN;
			ST_SCAN: begin
				if (rd_addr_q == end_q) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: state_d = op_query_q ? ST_DONE : ST_IDLE;
			ST_DONE: begin
				if (done_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		rd_issue  = (state_q == ST_FETCH) || (state_q == ST_SCAN);
		rd_addr   = (state_q == ST_FETCH) ? k_q : rd_addr_q;
		done_fire = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_count_q <= ENTRY_COUNT_RESET;
			vld_s1        <= 1'b0;
			fetch_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			vld_s1   <= rd_issue;
			fetch_s1 <= (state_q == ST_FETCH);
			if (cfg_valid && cfg_ready) begin
				entry_count_q <= entry_count;
			end
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item registers, scan address and result word
	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		if (accept) begin
			op_query_q <= is_query;
			k_q        <= idx_w[ADDR_W-1:0];
			newv_q     <= vext[VALUE_BITS-1:0];
			lo_q       <= lo_w[ADDR_W-1:0];
			end_q      <= is_query ? hic_w[ADDR_W-1:0] : ADDR_W'(DEPTH - 1);
			rd_addr_q  <= is_query ? lo_w[ADDR_W-1:0] : '0;
		end else if (state_q == ST_SCAN) begin
			rd_addr_q <= rd_addr_q + 1'b1;
		end
		if (done_fire) begin
			distinct_count_q <= count;
		end
	end

	assign ctl.clear = accept;
	assign ctl.vld   = vld_s1;
	assign ctl.fetch = fetch_s1;
	assign ctl.query = op_query_q;

	rdc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (wdata),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	rdc_unit #(
		.ADDR_W     (ADDR_W),
		.VALUE_BITS (VALUE_BITS)
	) u_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.addr    (addr_s1),
		.k       (k_q),
		.newv    (newv_q),
		.lo      (lo_q),
		.rd_word (rd_word),
		.we      (we),
		.wdata   (wdata),
		.count   (count)
	);

	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign distinct_count = distinct_count_q;

	a_data_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_SCAN || state_q == ST_FLUSH))
		else $error("read data returned outside a scan");

	a_done_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> op_query_q)
		else $error("load reached the result state");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (WIDE_W'(distinct_count_q) <= DEPTH_W))
		else $error("distinct count exceeds store depth");

endmodule

`default_nettype wire

### rtl/rdc_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/rdc_unit.sv
// Shared compare unit: previous-match tracking for loads, counting for queries.
`timescale 1ns / 1ps
`default_nettype none

module rdc_unit #(
	parameter int ADDR_W     = 10,
	parameter int VALUE_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rdc_pkg::rdc_ctl_t              ctl,
	input  wire logic [ADDR_W-1:0]              addr,
	input  wire logic [ADDR_W-1:0]              k,
	input  wire logic [VALUE_BITS-1:0]          newv,
	input  wire logic [ADDR_W-1:0]              lo,
	input  wire logic [VALUE_BITS+ADDR_W:0]     rd_word,
	output logic                                we,
	output logic      [VALUE_BITS+ADDR_W:0]     wdata,
	output logic      [rdc_pkg::COUNT_W-1:0]    count
);
	import rdc_pkg::*;

	// Word layout: value, previous-match valid, previous-match index
	logic [VALUE_BITS-1:0] v;
	logic                  pv;
	logic [ADDR_W-1:0]     pp;

	logic [VALUE_BITS-1:0] old_q;
	logic                  same_q;
	logic                  last_new_vld_q, last_old_vld_q;
	logic [ADDR_W-1:0]     last_new_q, last_old_q;
	logic                  done_new_q, done_old_q;
	logic [COUNT_W-1:0]    count_q;

	logic hit_new, hit_old, a_lt, a_eq, a_gt, scan_ld, dup;
	logic wr_k, wr_new, wr_old;

	assign v  = rd_word[VALUE_BITS+ADDR_W -: VALUE_BITS];
	assign pv = rd_word[ADDR_W];
	assign pp = rd_word[ADDR_W-1:0];

	assign hit_new = (v == newv);
	assign hit_old = (v == old_q);
	assign a_lt    = (addr < k);
	assign a_eq    = (addr == k);
	assign a_gt    = !a_lt && !a_eq;
	assign scan_ld = ctl.vld && !ctl.fetch && !ctl.query;
	assign dup     = pv && (pp >= lo);

	// The first later copy of the new value now points back at k; the first
	// later copy of the displaced value points at its last copy below k.
	assign wr_k   = scan_ld && a_eq;
	assign wr_new = scan_ld && a_gt && !done_new_q && hit_new;
	assign wr_old = scan_ld && a_gt && !wr_new && !same_q && !done_old_q && hit_old;

	always_comb begin
		we    = wr_k || wr_new || wr_old;
		wdata = rd_word;
		if (wr_k) begin
			wdata = {newv, last_new_vld_q, last_new_q};
		end else if (wr_new) begin
			wdata = {v, 1'b1, k};
		end else if (wr_old) begin
			wdata = {v, last_old_vld_q, last_old_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_new_vld_q <= 1'b0;
			last_old_vld_q <= 1'b0;
			done_new_q     <= 1'b0;
			done_old_q     <= 1'b0;
			count_q        <= '0;
		end else if (ctl.clear) begin
			last_new_vld_q <= 1'b0;
			last_old_vld_q <= 1'b0;
			done_new_q     <= 1'b0;
			done_old_q     <= 1'b0;
			count_q        <= '0;
		end else if (ctl.vld && !ctl.fetch) begin
			if (ctl.query) begin
				if (!dup) begin
					count_q <= count_q + 1'b1;
				end
			end else begin
				if (a_lt && hit_new) begin
					last_new_vld_q <= 1'b1;
				end
				if (a_lt && hit_old) begin
					last_old_vld_q <= 1'b1;
				end
				if (wr_new) begin
					done_new_q <= 1'b1;
				end
				if (wr_old) begin
					done_old_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld && ctl.fetch) begin
			old_q  <= v;
			same_q <= hit_new;
		end
		if (scan_ld && a_lt && hit_new) begin
			last_new_q <= addr;
		end
		if (scan_ld && a_lt && hit_old) begin
			last_old_q <= addr;
		end
	end

	assign count = count_q;

	a_wr_only_in_load_scan: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> scan_ld)
		else $error("store written outside a load scan");

	a_target_always_written: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_ld && addr == k) |-> (we && wdata[VALUE_BITS+ADDR_W -: VALUE_BITS] == newv))
		else $error("load target not written with the new value");

endmodule

`default_nettype wire
